// File: hdl/deadline_sorted_timer_queue_defines.svh
// ----------------------------------------------------------------------------
// Deadline sorted timer queue assertion macros
// Assertion helpers shared by the RTL files of the timer queue.
// ----------------------------------------------------------------------------
`ifndef DEADLINE_SORTED_TIMER_QUEUE_DEFINES_SVH
`define DEADLINE_SORTED_TIMER_QUEUE_DEFINES_SVH

`ifndef SYNTHESIS
// Checks an expression at every rising clock edge outside reset.
`define DSTQ_ASSERT(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("timer queue assertion failed");
// Checks that a trigger is followed in the next clock cycle by a consequence.
`define DSTQ_ASSERT_NEXT(label, clk, rst, trig, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) \
      else $error("timer queue assertion failed");
`else
`define DSTQ_ASSERT(label, clk, rst, expr)
`define DSTQ_ASSERT_NEXT(label, clk, rst, trig, cons)
`endif

`endif

// File: hdl/dstq_pkg.sv
// ----------------------------------------------------------------------------
// Timer queue package
// Types, codes and constants shared by the timer queue modules.
// ----------------------------------------------------------------------------
package dstq_pkg;

   localparam int DEPTH_DEFAULT = 16;
   // At most this many messages leave on one tick.
   localparam int RESULT_LIMIT  = 16;
   localparam int N_W           = $clog2(RESULT_LIMIT + 1);

   localparam int TIME_W    = 32;
   localparam int DELAY_W   = 16;
   localparam int HANDLER_W = 8;
   localparam int MESSAGE_W = 32;
   localparam int OCC_W     = 5;
   localparam int KIND_W    = 2;

   localparam logic ACTION_INSERT = 1'b0;
   localparam logic ACTION_TICK   = 1'b1;

   typedef enum logic [KIND_W-1:0] {
      KIND_ACCEPTED   = 2'd0,
      KIND_REJECTED   = 2'd1,
      KIND_DISPATCHED = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      ALU_ADD,
      ALU_LATER,
      ALU_REACHED
   } alu_op_type;

   typedef struct packed {
      alu_op_type          op;
      logic [TIME_W-1:0]   a;
      logic [TIME_W-1:0]   b;
   } alu_req_type;

   typedef struct packed {
      logic [TIME_W-1:0]   result;
      logic                flag;
   } alu_rsp_type;

   typedef struct packed {
      logic [TIME_W-1:0]    deadline;
      logic [HANDLER_W-1:0] handler;
      logic [MESSAGE_W-1:0] message;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_INS_ADD,
      ST_INS_RD,
      ST_INS_CMP,
      ST_INS_PUT,
      ST_INS_RESP,
      ST_REJECT,
      ST_TICK_INC,
      ST_TICK_CHK,
      ST_TICK_CMP,
      ST_TICK_END
   } state_type;

endpackage

// File: hdl/dstq_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module dstq_ram #(
   parameter int WIDTH = dstq_pkg::ENTRY_W,
   parameter int DEPTH = dstq_pkg::DEPTH_DEFAULT,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/dstq_alu.sv
// ----------------------------------------------------------------------------
// Timer queue arithmetic unit
// One 32-bit adder that computes deadlines and wrap-safe deadline compares.
// ----------------------------------------------------------------------------
module dstq_alu (
   input  dstq_pkg::alu_req_type req,
   output dstq_pkg::alu_rsp_type rsp
);

   logic                        sub;
   logic [dstq_pkg::TIME_W-1:0] b_opnd;
   logic [dstq_pkg::TIME_W-1:0] sum;

   always_comb begin
      // Compares subtract: a + ~b + 1.
      sub    = (req.op != dstq_pkg::ALU_ADD);
      b_opnd = sub ? ~req.b : req.b;
      sum    = req.a + b_opnd + {{(dstq_pkg::TIME_W-1){1'b0}}, sub};
      rsp.result = sum;
      case (req.op)
         dstq_pkg::ALU_LATER: begin
            rsp.flag = (sum != '0) && !sum[dstq_pkg::TIME_W-1];
         end
         dstq_pkg::ALU_REACHED: begin
            rsp.flag = !sum[dstq_pkg::TIME_W-1];
         end
         default: begin
            rsp.flag = 1'b0;
         end
      endcase
   end

endmodule

// File: hdl/deadline_sorted_timer_queue.sv
// ----------------------------------------------------------------------------
// Deadline sorted timer queue
// Holds pending messages sorted by deadline and releases them on ticks.
// ----------------------------------------------------------------------------
// An insert transfer (tuser 0) queues a message due delay_ticks after the
// current time and always answers with one status transfer: accepted, or
// rejected when all QUEUE_DEPTH slots are taken. A tick transfer (tuser 1)
// advances the 32-bit time counter and then sends every message that has
// come due, oldest deadline first and equal deadlines in arrival order, at
// most sixteen per tick, with tlast on the final one; a tick with nothing
// due sends nothing. The block takes one transfer at a time. An accepted
// insert moves each held entry whose deadline is later than the new one up
// by one slot, reading and rewriting it through the single port pair of the
// entry RAM, whose read data is registered; when some held entry is not
// later, that entry is read and compared before the new one is written
// above it. A tick reads and compares each head entry in the same way, one
// per message sent, and also reads the head entry that stops it when that
// one is not yet due. The sequencer then returns to idle before it takes
// the next transfer, and a result side that stalls a waiting result holds
// it back further. No clearing pass is needed after reset; only slots
// holding live entries are ever read.
// ----------------------------------------------------------------------------
`include "deadline_sorted_timer_queue_defines.svh"

module deadline_sorted_timer_queue #(
   parameter int QUEUE_DEPTH = dstq_pkg::DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_tvalid,
   output logic        req_tready,
   // [15:0] delay_ticks, [23:16] handler_id, [55:24] message_word
   input  logic [55:0] req_tdata,
   // [0] action
   input  logic        req_tuser,

   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [7:0] out_handler, [39:8] out_message, [44:40] occupancy, [47:45] zero
   output logic [47:0] rsp_tdata,
   // [1:0] kind
   output logic [1:0]  rsp_tuser,
   output logic        rsp_tlast
);

   localparam int AW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam logic [AW:0]   DEPTH_WIDE  = (AW + 1)'(QUEUE_DEPTH);
   localparam logic [CW-1:0] DEPTH_COUNT = CW'(QUEUE_DEPTH);
   localparam logic [dstq_pkg::N_W-1:0] LIMIT_N = dstq_pkg::N_W'(dstq_pkg::RESULT_LIMIT);

   // Adds an offset to a slot pointer around the circular entry table.
   function automatic logic [AW-1:0] wrap_add(logic [AW-1:0] base, logic [AW-1:0] ofs);
      logic [AW:0] s;
      s = {1'b0, base} + {1'b0, ofs};
      if (s >= DEPTH_WIDE) begin
         s = s - DEPTH_WIDE;
      end
      return s[AW-1:0];
   endfunction

   dstq_pkg::state_type state_ff, state_in;

   logic [dstq_pkg::TIME_W-1:0]    now_ff, now_in;
   logic [CW-1:0]                  count_ff, count_in;
   logic [AW-1:0]                  head_ff, head_in;
   logic [AW-1:0]                  idx_ff, idx_in;
   logic [dstq_pkg::TIME_W-1:0]    deadline_ff, deadline_in;
   logic [dstq_pkg::N_W-1:0]       n_ff, n_in;

   logic [dstq_pkg::DELAY_W-1:0]   in_delay_ff, in_delay_in;
   logic [dstq_pkg::HANDLER_W-1:0] in_handler_ff, in_handler_in;
   logic [dstq_pkg::MESSAGE_W-1:0] in_message_ff, in_message_in;

   // One dispatched message is held back until it is known whether it is
   // the final one of its tick.
   logic                           pend_valid_ff, pend_valid_in;
   logic [dstq_pkg::HANDLER_W-1:0] pend_handler_ff, pend_handler_in;
   logic [dstq_pkg::MESSAGE_W-1:0] pend_message_ff, pend_message_in;
   logic [dstq_pkg::OCC_W-1:0]     pend_occ_ff, pend_occ_in;

   // Result register, which lets the sequencer run on while a result waits.
   logic                           rsp_valid_ff, rsp_valid_in;
   dstq_pkg::kind_type             rsp_kind_ff, rsp_kind_in;
   logic [dstq_pkg::HANDLER_W-1:0] rsp_handler_ff, rsp_handler_in;
   logic [dstq_pkg::MESSAGE_W-1:0] rsp_message_ff, rsp_message_in;
   logic [dstq_pkg::OCC_W-1:0]     rsp_occ_ff, rsp_occ_in;
   logic                           rsp_last_ff, rsp_last_in;

   logic                           ram_wr_en;
   logic [AW-1:0]                  ram_wr_addr;
   dstq_pkg::entry_type            ram_wr_entry;
   logic                           ram_rd_en;
   logic [AW-1:0]                  ram_rd_addr;
   logic [dstq_pkg::ENTRY_W-1:0]   ram_rd_data;
   dstq_pkg::entry_type            rd_entry;

   dstq_pkg::alu_req_type          alu_req;
   dstq_pkg::alu_rsp_type          alu_rsp;

   logic                           out_free;
   dstq_pkg::entry_type            new_entry;

   dstq_ram #(
      .WIDTH (dstq_pkg::ENTRY_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_entry),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   dstq_alu u_alu (
      .req (alu_req),
      .rsp (alu_rsp)
   );

   assign rd_entry   = dstq_pkg::entry_type'(ram_rd_data);
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == dstq_pkg::ST_IDLE);

   always_comb begin
      new_entry.deadline = deadline_ff;
      new_entry.handler  = in_handler_ff;
      new_entry.message  = in_message_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= dstq_pkg::ST_IDLE;
         now_ff        <= '0;
         count_ff      <= '0;
         head_ff       <= '0;
         n_ff          <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         now_ff        <= now_in;
         count_ff      <= count_in;
         head_ff       <= head_in;
         n_ff          <= n_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff          <= idx_in;
      deadline_ff     <= deadline_in;
      in_delay_ff     <= in_delay_in;
      in_handler_ff   <= in_handler_in;
      in_message_ff   <= in_message_in;
      pend_handler_ff <= pend_handler_in;
      pend_message_ff <= pend_message_in;
      pend_occ_ff     <= pend_occ_in;
      rsp_kind_ff     <= rsp_kind_in;
      rsp_handler_ff  <= rsp_handler_in;
      rsp_message_ff  <= rsp_message_in;
      rsp_occ_ff      <= rsp_occ_in;
      rsp_last_ff     <= rsp_last_in;
   end

   always_comb begin
      state_in        = state_ff;
      now_in          = now_ff;
      count_in        = count_ff;
      head_in         = head_ff;
      idx_in          = idx_ff;
      deadline_in     = deadline_ff;
      n_in            = n_ff;
      in_delay_in     = in_delay_ff;
      in_handler_in   = in_handler_ff;
      in_message_in   = in_message_ff;
      pend_valid_in   = pend_valid_ff;
      pend_handler_in = pend_handler_ff;
      pend_message_in = pend_message_ff;
      pend_occ_in     = pend_occ_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_tready;
      rsp_kind_in     = rsp_kind_ff;
      rsp_handler_in  = rsp_handler_ff;
      rsp_message_in  = rsp_message_ff;
      rsp_occ_in      = rsp_occ_ff;
      rsp_last_in     = rsp_last_ff;

      ram_wr_en    = 1'b0;
      ram_wr_addr  = head_ff;
      ram_wr_entry = new_entry;
      ram_rd_en    = 1'b0;
      ram_rd_addr  = head_ff;

      alu_req.op = dstq_pkg::ALU_ADD;
      alu_req.a  = now_ff;
      alu_req.b  = dstq_pkg::TIME_W'(in_delay_ff);

      case (state_ff)
         dstq_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               in_delay_in   = req_tdata[15:0];
               in_handler_in = req_tdata[23:16];
               in_message_in = req_tdata[55:24];
               if (req_tuser == dstq_pkg::ACTION_TICK) begin
                  state_in = dstq_pkg::ST_TICK_INC;
               end else if (count_ff >= DEPTH_COUNT) begin
                  state_in = dstq_pkg::ST_REJECT;
               end else begin
                  state_in = dstq_pkg::ST_INS_ADD;
               end
            end
         end

         dstq_pkg::ST_INS_ADD: begin
            deadline_in = alu_rsp.result;
            if (count_ff == '0) begin
               state_in = dstq_pkg::ST_INS_PUT;
            end else begin
               idx_in   = AW'(count_ff - CW'(1));
               state_in = dstq_pkg::ST_INS_RD;
            end
         end

         dstq_pkg::ST_INS_RD: begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = wrap_add(head_ff, idx_ff);
            state_in    = dstq_pkg::ST_INS_CMP;
         end

         dstq_pkg::ST_INS_CMP: begin
            // Entries due later than the new one move up a slot; the new
            // entry lands just above the first one that is not later.
            alu_req.op  = dstq_pkg::ALU_LATER;
            alu_req.a   = rd_entry.deadline;
            alu_req.b   = deadline_ff;
            ram_wr_en   = 1'b1;
            ram_wr_addr = wrap_add(head_ff, idx_ff + AW'(1));
            if (alu_rsp.flag) begin
               ram_wr_entry = rd_entry;
               if (idx_ff == '0) begin
                  state_in = dstq_pkg::ST_INS_PUT;
               end else begin
                  idx_in   = idx_ff - AW'(1);
                  state_in = dstq_pkg::ST_INS_RD;
               end
            end else begin
               state_in = dstq_pkg::ST_INS_RESP;
            end
         end

         dstq_pkg::ST_INS_PUT: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = head_ff;
            state_in    = dstq_pkg::ST_INS_RESP;
         end

         dstq_pkg::ST_INS_RESP: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_kind_in    = dstq_pkg::KIND_ACCEPTED;
               rsp_handler_in = '0;
               rsp_message_in = '0;
               rsp_occ_in     = dstq_pkg::OCC_W'(count_ff + CW'(1));
               rsp_last_in    = 1'b1;
               count_in       = count_ff + CW'(1);
               state_in       = dstq_pkg::ST_IDLE;
            end
         end

         dstq_pkg::ST_REJECT: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_kind_in    = dstq_pkg::KIND_REJECTED;
               rsp_handler_in = '0;
               rsp_message_in = '0;
               rsp_occ_in     = dstq_pkg::OCC_W'(count_ff);
               rsp_last_in    = 1'b1;
               state_in       = dstq_pkg::ST_IDLE;
            end
         end

         dstq_pkg::ST_TICK_INC: begin
            alu_req.b     = dstq_pkg::TIME_W'(1);
            now_in        = alu_rsp.result;
            n_in          = '0;
            pend_valid_in = 1'b0;
            state_in      = dstq_pkg::ST_TICK_CHK;
         end

         dstq_pkg::ST_TICK_CHK: begin
            if ((count_ff == '0) || (n_ff == LIMIT_N)) begin
               state_in = dstq_pkg::ST_TICK_END;
            end else begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = head_ff;
               state_in    = dstq_pkg::ST_TICK_CMP;
            end
         end

         dstq_pkg::ST_TICK_CMP: begin
            alu_req.op = dstq_pkg::ALU_REACHED;
            alu_req.a  = now_ff;
            alu_req.b  = rd_entry.deadline;
            if (!alu_rsp.flag) begin
               state_in = dstq_pkg::ST_TICK_END;
            end else if (!pend_valid_ff || out_free) begin
               // A further due entry means the held one is not the last.
               if (pend_valid_ff) begin
                  rsp_valid_in   = 1'b1;
                  rsp_kind_in    = dstq_pkg::KIND_DISPATCHED;
                  rsp_handler_in = pend_handler_ff;
                  rsp_message_in = pend_message_ff;
                  rsp_occ_in     = pend_occ_ff;
                  rsp_last_in    = 1'b0;
               end
               pend_valid_in   = 1'b1;
               pend_handler_in = rd_entry.handler;
               pend_message_in = rd_entry.message;
               pend_occ_in     = dstq_pkg::OCC_W'(count_ff - CW'(1));
               head_in         = wrap_add(head_ff, AW'(1));
               count_in        = count_ff - CW'(1);
               n_in            = n_ff + dstq_pkg::N_W'(1);
               state_in        = dstq_pkg::ST_TICK_CHK;
            end
         end

         dstq_pkg::ST_TICK_END: begin
            if (!pend_valid_ff) begin
               state_in = dstq_pkg::ST_IDLE;
            end else if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_kind_in    = dstq_pkg::KIND_DISPATCHED;
               rsp_handler_in = pend_handler_ff;
               rsp_message_in = pend_message_ff;
               rsp_occ_in     = pend_occ_ff;
               rsp_last_in    = 1'b1;
               pend_valid_in  = 1'b0;
               state_in       = dstq_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = dstq_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, rsp_occ_ff, rsp_message_ff, rsp_handler_ff};
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;

   // The table never holds more entries than it has slots.
   `DSTQ_ASSERT(a_count_bound, clock, reset, count_ff <= DEPTH_COUNT)
   // A single tick never sends more than the per-tick limit.
   `DSTQ_ASSERT(a_tick_limit, clock, reset, n_ff <= LIMIT_N)
   // A held-back message exists only while a tick is being worked off.
   `DSTQ_ASSERT(a_pend_in_tick, clock, reset,
      !pend_valid_ff || (state_ff == dstq_pkg::ST_TICK_CHK) ||
      (state_ff == dstq_pkg::ST_TICK_CMP) || (state_ff == dstq_pkg::ST_TICK_END))
   // An accepted transfer always moves the sequencer out of idle.
   `DSTQ_ASSERT_NEXT(a_accept_busy, clock, reset, req_tvalid && req_tready,
      state_ff != dstq_pkg::ST_IDLE)
   // A tick advances the time counter by exactly one.
   `DSTQ_ASSERT_NEXT(a_tick_step, clock, reset, state_ff == dstq_pkg::ST_TICK_INC,
      now_ff == $past(now_ff) + 32'd1)

endmodule

// File: verif/tb_deadline_sorted_timer_queue.sv
// ----------------------------------------------------------------------------
// Deadline sorted timer queue testbench
// Drives insert and tick transfers into the timer queue and checks every
// status and dispatch transfer against a behavioral model of the sorted table.
// ----------------------------------------------------------------------------
// A scoreboard process watches both channels. Each accepted input transfer
// is applied to the model, which appends the transfers it expects to a
// queue; each accepted result transfer is compared field by field with the
// oldest entry of that queue. Directed tests cover a full table, a rejected
// insert, a sixteen-message burst and deadline ordering. A back-pressure test
// stalls the result side long enough for the block to stall its input. Four
// random phases then vary idling on either side.
// ----------------------------------------------------------------------------
module tb_deadline_sorted_timer_queue;

   localparam int DEPTH        = dstq_pkg::DEPTH_DEFAULT;
   // Slowest legal run is far below this; only a hang should reach it.
   localparam int CYCLE_LIMIT  = 300000;
   // A tick with nothing due still keeps the block busy, though no result marks its end.
   localparam int SETTLE_CYCLES = 40;
   localparam int HOLD_CYCLES  = 300;

   // One expected result transfer.
   typedef struct {
      dstq_pkg::kind_type               kind;
      logic [dstq_pkg::HANDLER_W-1:0]   handler;
      logic [dstq_pkg::MESSAGE_W-1:0]   message;
      logic [dstq_pkg::OCC_W-1:0]       occupancy;
      logic                             last;
   } timer_result_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   // [15:0] delay_ticks, [23:16] handler_id, [55:24] message_word
   logic [55:0] req_tdata  = '0;
   // [0] action
   logic        req_tuser  = dstq_pkg::ACTION_INSERT;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   // [7:0] out_handler, [39:8] out_message, [44:40] occupancy, [47:45] zero
   logic [47:0] rsp_tdata;
   // [1:0] kind
   logic [1:0]  rsp_tuser;
   logic        rsp_tlast;

   // Model of the table: time counter and deadline-sorted slots.
   logic [dstq_pkg::TIME_W-1:0]    clock_now = '0;
   logic [dstq_pkg::TIME_W-1:0]    slot_deadline [DEPTH];
   logic [dstq_pkg::HANDLER_W-1:0] slot_handler  [DEPTH];
   logic [dstq_pkg::MESSAGE_W-1:0] slot_message  [DEPTH];
   int                             held = 0;

   timer_result_type awaited_results[$];

   // Idling knobs, in percent, and the long receiver hold-off request.
   int unsigned req_idle_pct  = 0;
   int unsigned rsp_stall_pct = 0;
   int unsigned hold_asked    = 0;
   int unsigned hold_seen     = 0;
   int unsigned hold_left     = 0;

   int unsigned mismatches      = 0;
   int unsigned cycle_count     = 0;
   int unsigned inserts_seen    = 0;
   int unsigned rejects_seen    = 0;
   int unsigned ticks_seen      = 0;
   int unsigned dispatched_seen = 0;
   int unsigned widest_burst    = 0;

   deadline_sorted_timer_queue #(.QUEUE_DEPTH(DEPTH)) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #5 clock = ~clock;

   // Hang guard: ends the run if the block stops making progress.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles with %0d results outstanding.",
                  cycle_count, awaited_results.size());
         $display("tb: failure");
         $finish;
      end
   end

   // Result-side readiness. A hold-off request from a test forces tready low
   // for a long stretch, counted here; otherwise tready stalls at random.
   always @(posedge clock) begin
      if (hold_asked != hold_seen) begin
         hold_seen = hold_asked;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // Applies one accepted input transfer to the table model and queues the
   // result transfers it must cause.
   function automatic void timer_apply(input logic act,
                                       input logic [dstq_pkg::DELAY_W-1:0] dly,
                                       input logic [dstq_pkg::HANDLER_W-1:0] hid,
                                       input logic [dstq_pkg::MESSAGE_W-1:0] msg);
      logic [dstq_pkg::TIME_W-1:0] due;
      logic [dstq_pkg::TIME_W-1:0] gap;
      timer_result_type            rec;
      int                          pos;
      int                          i;
      int unsigned                 sent;
      rec.handler = '0;
      rec.message = '0;
      rec.last    = 1'b1;
      if (act == dstq_pkg::ACTION_INSERT) begin
         inserts_seen++;
         if (held >= DEPTH) begin
            rejects_seen++;
            rec.kind      = dstq_pkg::KIND_REJECTED;
            rec.occupancy = dstq_pkg::OCC_W'(held);
            awaited_results.push_back(rec);
         end else begin
            due = clock_now + dstq_pkg::TIME_W'(dly);
            // Skip every entry whose deadline is not later, so equal
            // deadlines keep arrival order.
            pos = 0;
            while (pos < held) begin
               gap = slot_deadline[pos] - due;
               if (gap != '0 && !gap[dstq_pkg::TIME_W-1])
                  break;
               pos++;
            end
            for (i = held; i > pos; i--) begin
               slot_deadline[i] = slot_deadline[i-1];
               slot_handler[i]  = slot_handler[i-1];
               slot_message[i]  = slot_message[i-1];
            end
            slot_deadline[pos] = due;
            slot_handler[pos]  = hid;
            slot_message[pos]  = msg;
            held++;
            rec.kind      = dstq_pkg::KIND_ACCEPTED;
            rec.occupancy = dstq_pkg::OCC_W'(held);
            awaited_results.push_back(rec);
         end
      end else begin
         ticks_seen++;
         clock_now = clock_now + dstq_pkg::TIME_W'(1);
         sent = 0;
         while (sent < dstq_pkg::RESULT_LIMIT && held > 0) begin
            // Wrap-safe test: the head is due unless its deadline lies ahead.
            gap = clock_now - slot_deadline[0];
            if (gap[dstq_pkg::TIME_W-1])
               break;
            rec.kind    = dstq_pkg::KIND_DISPATCHED;
            rec.handler = slot_handler[0];
            rec.message = slot_message[0];
            rec.last    = 1'b0;
            for (i = 0; i < held - 1; i++) begin
               slot_deadline[i] = slot_deadline[i+1];
               slot_handler[i]  = slot_handler[i+1];
               slot_message[i]  = slot_message[i+1];
            end
            held--;
            rec.occupancy = dstq_pkg::OCC_W'(held);
            awaited_results.push_back(rec);
            sent++;
         end
         if (sent > 0)
            awaited_results[awaited_results.size()-1].last = 1'b1;
         dispatched_seen += sent;
         if (sent > widest_burst)
            widest_burst = sent;
      end
   endfunction

   task automatic report_mismatch(input string what);
      $display("ERROR at cycle %0d: %s", cycle_count, what);
      mismatches++;
   endtask

   task automatic check_field(input string name, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s is 0x%0h, expected 0x%0h", name, got, want));
   endtask

   // Scoreboard. Both channels are sampled at the same edge at which the
   // transfer happens, so the values seen are the ones the block saw.
   always @(posedge clock) begin : scoreboard
      timer_result_type want;
      if (!reset) begin
         if (req_tvalid && req_tready)
            timer_apply(req_tuser, req_tdata[15:0], req_tdata[23:16],
                        req_tdata[55:24]);
         if (rsp_tvalid && rsp_tready) begin
            if (awaited_results.size() == 0) begin
               report_mismatch($sformatf("result of kind %0d with none expected",
                                         rsp_tuser));
            end else begin
               want = awaited_results.pop_front();
               check_field("kind", 32'(rsp_tuser), 32'(want.kind));
               check_field("handler", 32'(rsp_tdata[7:0]), 32'(want.handler));
               check_field("message", rsp_tdata[39:8], want.message);
               check_field("occupancy", 32'(rsp_tdata[44:40]), 32'(want.occupancy));
               check_field("padding", 32'(rsp_tdata[47:45]), 32'd0);
               check_field("last", 32'(rsp_tlast), 32'(want.last));
            end
         end
      end
   end

   // Offers one input transfer, after a random idle gap, and returns at the
   // edge where it is accepted. tvalid stays high into the next call unless
   // that call idles first, so it is never lowered and raised in one step.
   task automatic send_item(input logic act,
                            input logic [dstq_pkg::DELAY_W-1:0] dly,
                            input logic [dstq_pkg::HANDLER_W-1:0] hid,
                            input logic [dstq_pkg::MESSAGE_W-1:0] msg);
      while ($urandom_range(99) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tdata  <= {msg, hid, dly};
      do
         @(posedge clock);
      while (!req_tready);
   endtask

   // Holds the sender until every expected result has arrived, then lets
   // the block finish any tick that had nothing to send. The first edge
   // lets the scoreboard book the transfer accepted just before.
   task automatic wait_for_drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (awaited_results.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Sixteen zero-delay inserts fill the table, a seventeenth carrying the
   // largest field values is rejected, and one tick then releases all
   // sixteen in arrival order with tlast on the final one.
   task automatic test_full_table_burst();
      int i;
      for (i = 0; i < DEPTH; i++)
         send_item(dstq_pkg::ACTION_INSERT, '0, dstq_pkg::HANDLER_W'(i), $urandom);
      send_item(dstq_pkg::ACTION_INSERT, '1, '1, '1);
      send_item(dstq_pkg::ACTION_TICK, '0, '0, '0);
      wait_for_drain();
   endtask

   // Mixed delays inserted at one time: the zero-delay and one-tick entries
   // leave together on the next tick, a tick with nothing due sends nothing,
   // and the two equal three-tick entries leave in arrival order.
   task automatic test_deadline_order();
      send_item(dstq_pkg::ACTION_INSERT, 16'd3, 8'h01, 32'h0000_0001);
      send_item(dstq_pkg::ACTION_INSERT, 16'd1, 8'h02, 32'h8000_0000);
      send_item(dstq_pkg::ACTION_INSERT, 16'd3, 8'h03, 32'h5A5A_A5A5);
      send_item(dstq_pkg::ACTION_INSERT, 16'd0, 8'h00, 32'h0000_0000);
      send_item(dstq_pkg::ACTION_TICK, '0, '0, '0);
      send_item(dstq_pkg::ACTION_TICK, '0, '0, '0);
      send_item(dstq_pkg::ACTION_TICK, '0, '0, '0);
      wait_for_drain();
   endtask

   // The receiver holds off for a long stretch while inserts keep coming,
   // so the block has to stall its input; the table overflows on the way.
   task automatic test_result_backpressure();
      int i;
      hold_asked++;
      for (i = 0; i < 20; i++)
         send_item(dstq_pkg::ACTION_INSERT, dstq_pkg::DELAY_W'($urandom_range(8)),
                   dstq_pkg::HANDLER_W'($urandom), $urandom);
      for (i = 0; i < 12; i++)
         send_item(dstq_pkg::ACTION_TICK, dstq_pkg::DELAY_W'($urandom),
                   dstq_pkg::HANDLER_W'($urandom), $urandom);
      wait_for_drain();
   endtask

   // Random traffic that alternates between filling and draining runs.
   // Delays are mostly short so entries come due; a few span the full
   // field, limited so that far-off entries cannot clog the table.
   task automatic test_random_traffic(input int unsigned idle_pct,
                                      input int unsigned stall_pct,
                                      input int unsigned count);
      int unsigned                  n;
      int unsigned                  pick;
      int                           far_held;
      int                           k;
      logic                         fill_mode;
      logic                         act;
      logic [dstq_pkg::DELAY_W-1:0] dly;
      logic [dstq_pkg::TIME_W-1:0]  ahead;
      req_idle_pct  = idle_pct;
      rsp_stall_pct = stall_pct;
      fill_mode     = 1'b1;
      for (n = 0; n < count; n++) begin
         if ($urandom_range(19) == 0)
            fill_mode = !fill_mode;
         act = ($urandom_range(99) < (fill_mode ? 25 : 70)) ? dstq_pkg::ACTION_TICK
                                                            : dstq_pkg::ACTION_INSERT;
         far_held = 0;
         for (k = 0; k < held; k++) begin
            ahead = slot_deadline[k] - clock_now;
            if (ahead > 1000 && !ahead[dstq_pkg::TIME_W-1])
               far_held++;
         end
         pick = $urandom_range(99);
         if (pick < 4 && far_held < 4)
            dly = dstq_pkg::DELAY_W'($urandom_range(65535));
         else if (pick < 20)
            dly = dstq_pkg::DELAY_W'($urandom_range(60));
         else
            dly = dstq_pkg::DELAY_W'($urandom_range(10));
         send_item(act, dly, dstq_pkg::HANDLER_W'($urandom), $urandom);
      end
      wait_for_drain();
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_full_table_burst();
      test_deadline_order();
      test_result_backpressure();
      test_random_traffic(0, 0, 100);
      test_random_traffic(60, 0, 95);
      test_random_traffic(0, 60, 95);
      test_random_traffic(37, 37, 95);

      if (awaited_results.size() != 0)
         report_mismatch($sformatf("%0d results never arrived",
                                   awaited_results.size()));

      $display("Run covered %0d inserts (%0d turned away as full) and %0d ticks,",
               inserts_seen, rejects_seen, ticks_seen);
      $display("with %0d messages dispatched, up to %0d on a single tick.",
               dispatched_seen, widest_burst);
      if (mismatches == 0) begin
         $display("tb: success");
      end else begin
         $display("%0d mismatches found.", mismatches);
         $display("tb: failure");
      end
      $finish;
   end

endmodule
